// ===== rtl/linemarker_include_scanner_assert.svh =====
// Assertion macros used by the port checker of the line-marker scanner.
`ifndef LINEMARKER_INCLUDE_SCANNER_ASSERT_SVH
`define LINEMARKER_INCLUDE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scanner port check failed");

// Next-cycle implication, disabled while reset is low.
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scanner port check failed");

`endif

// ===== rtl/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Types and constants shared by the line-marker include scanner modules.
// ----------------------------------------------------------------------------
package lis_pkg;

    // Result kinds
    localparam logic [1:0] KIND_SPAN    = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_CORRUPT = 2'd2;

    // Characters the scanner matches
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Scan phases
    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_HASH,
        PH_L_I,
        PH_L_N,
        PH_L_E,
        PH_L_SP,
        PH_DIGITS,
        PH_QUOTE,
        PH_PATH_FIRST,
        PH_PATH,
        PH_FLAG_SP,
        PH_FLAG_ONE
    } t_phase;

    // Input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_buffer;
    } t_in;

    // Result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] path_start;
        logic [31:0] path_end;
        logic        last_of_run;
    } t_out;

    // All results caused by one byte, as queued between front and back
    typedef struct packed {
        logic        has_span;
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic        has_done;
        logic [1:0]  done_kind;
    } t_rec;

endpackage

// ===== rtl/lis_front.sv =====
// ----------------------------------------------------------------------------
// lis_front
// Byte scanner: tracks the line-marker pattern and turns each accepted byte
// into a record of the results it causes.
// ----------------------------------------------------------------------------
module lis_front
    import lis_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_push,
    output t_rec o_rec
);

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_prev, n_prev;
    logic [POS_WIDTH-1:0]   r_pos, n_pos;
    logic [POS_WIDTH-1:0]   r_path_begin, n_path_begin;
    logic [POS_WIDTH-1:0]   r_quote_at, n_quote_at;
    logic                   r_flags, n_flags;

    logic                   retry;
    logic                   span;
    logic [POS_WIDTH-1:0]   span_s;
    logic [POS_WIDTH-1:0]   span_e;
    logic [POS_WIDTH-1:0]   begin_v;
    logic                   prev_slash;
    logic [7:0]             b;
    logic                   eob;
    logic                   path_open;
    logic [63:0]            s_ext;
    logic [63:0]            e_ext;

    assign b          = i_item.text_byte;
    assign eob        = i_item.end_of_buffer;
    assign prev_slash = (r_prev == CH_SLASH) || (r_prev == CH_BSLASH);

    // Next state of the scanner for the byte on the input
    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_path_begin = r_path_begin;
        n_quote_at   = r_quote_at;
        n_prev       = r_prev;
        n_pos        = r_pos;
        retry        = 1'b0;
        span         = 1'b0;
        span_s       = r_path_begin;
        span_e       = r_pos;
        begin_v      = r_path_begin;

        unique case (r_phase)
            PH_HASH: begin
                if (b == CH_SPACE)  n_phase = PH_DIGITS;
                else if (b == CH_L) n_phase = PH_L_I;
                else                retry = 1'b1;
            end
            PH_L_I: begin
                if (b == CH_I) n_phase = PH_L_N;
                else           retry = 1'b1;
            end
            PH_L_N: begin
                if (b == CH_N) n_phase = PH_L_E;
                else           retry = 1'b1;
            end
            PH_L_E: begin
                if (b == CH_E) n_phase = PH_L_SP;
                else           retry = 1'b1;
            end
            PH_L_SP: begin
                if (b == CH_SPACE) begin
                    n_flags = 1'b0;
                    n_phase = PH_DIGITS;
                end else begin
                    retry = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (b >= CH_ZERO && b <= CH_NINE) n_phase = PH_DIGITS;
                else if (b == CH_SPACE)          n_phase = PH_QUOTE;
                else                              retry = 1'b1;
            end
            PH_QUOTE: begin
                if (b == CH_QUOTE) n_phase = PH_PATH_FIRST;
                else               retry = 1'b1;
            end
            PH_PATH_FIRST, PH_PATH: begin
                if (r_phase == PH_PATH_FIRST && b == CH_LT) begin
                    retry = 1'b1;
                end else begin
                    if (r_phase == PH_PATH_FIRST) begin
                        begin_v      = r_pos;
                        n_path_begin = r_pos;
                    end
                    if (b != CH_QUOTE) begin
                        n_phase = PH_PATH;
                    end else if (r_phase == PH_PATH && prev_slash) begin
                        // drop directory-like paths
                        n_phase = PH_SEARCH;
                    end else if (!r_flags) begin
                        span    = 1'b1;
                        span_s  = begin_v;
                        span_e  = r_pos;
                        n_phase = PH_SEARCH;
                    end else begin
                        n_quote_at = r_pos;
                        n_phase    = PH_FLAG_SP;
                    end
                end
            end
            PH_FLAG_SP: begin
                if (b == CH_SPACE) n_phase = PH_FLAG_ONE;
                else               retry = 1'b1;
            end
            PH_FLAG_ONE: begin
                if (b == CH_ONE) begin
                    span    = 1'b1;
                    span_s  = r_path_begin;
                    span_e  = r_quote_at;
                    n_phase = PH_SEARCH;
                end else begin
                    retry = 1'b1;
                end
            end
            default: retry = 1'b1;
        endcase

        // Rescan the breaking byte as a possible directive start
        if (retry) begin
            if (b == CH_HASH && (r_prev == CH_LF || r_prev == CH_CR)) n_phase = PH_HASH;
            else                                                      n_phase = PH_SEARCH;
        end

        path_open = (n_phase == PH_PATH) || (n_phase == PH_PATH_FIRST);

        // Return to reset state at buffer end, else advance the offset
        if (eob) begin
            n_phase      = PH_SEARCH;
            n_prev       = CH_LF;
            n_pos        = '0;
            n_path_begin = '0;
            n_quote_at   = '0;
            n_flags      = 1'b1;
        end else begin
            n_prev = b;
            if (r_pos != {POS_WIDTH{1'b1}}) n_pos = r_pos + 1'b1;
        end
    end

    // Keep the low 32 bits of the offsets
    assign s_ext = 64'(span_s);
    assign e_ext = 64'(span_e);

    always_comb begin
        o_rec.has_span   = span;
        o_rec.span_start = s_ext[31:0];
        o_rec.span_end   = e_ext[31:0];
        o_rec.has_done   = eob;
        o_rec.done_kind  = path_open ? KIND_CORRUPT : KIND_OK;
    end

    assign o_push = i_accept && (span || eob);

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_prev       <= CH_LF;
            r_pos        <= '0;
            r_path_begin <= '0;
            r_quote_at   <= '0;
            r_flags      <= 1'b1;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_prev       <= n_prev;
            r_pos        <= n_pos;
            r_path_begin <= n_path_begin;
            r_quote_at   <= n_quote_at;
            r_flags      <= n_flags;
        end
    end

endmodule

// ===== rtl/lis_queue.sv =====
// ----------------------------------------------------------------------------
// lis_queue
// Short record queue between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module lis_queue
    import lis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_rec,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_rec            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [AW:0]     r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = do_push ? AW'(r_wr + 1'b1) : r_wr;
        n_rd    = do_pop  ? AW'(r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store records
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_rec;
    end

endmodule

// ===== rtl/lis_back.sv =====
// ----------------------------------------------------------------------------
// lis_back
// Result sequencer: holds one record and hands out its span and buffer-done
// results, one transfer per cycle while records are queued and the receiver is ready.
// ----------------------------------------------------------------------------
module lis_back
    import lis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_rec i_rec,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_rec r_rec;
    logic r_valid, n_valid;
    logic r_second, n_second;
    logic show_span;
    logic final_res;

    // Span goes first when the record holds one
    assign show_span = r_rec.has_span && !r_second;
    assign final_res = !(show_span && r_rec.has_done);

    always_comb begin
        if (show_span) begin
            o_data.result_kind = KIND_SPAN;
            o_data.path_start  = r_rec.span_start;
            o_data.path_end    = r_rec.span_end;
            o_data.last_of_run = !r_rec.has_done;
        end else begin
            o_data.result_kind = r_rec.done_kind;
            o_data.path_start  = '0;
            o_data.path_end    = '0;
            o_data.last_of_run = 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_pop   = !i_empty && (!r_valid || (i_ready && final_res));

    // Load a new record or step to its second result
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (o_pop) begin
            n_valid  = 1'b1;
            n_second = 1'b0;
        end else if (r_valid && i_ready) begin
            if (final_res) begin
                n_valid = 1'b0;
            end else begin
                n_second = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
    end

endmodule

// ===== rtl/linemarker_include_scanner.sv =====
// Line-marker include scanner. Takes one byte of preprocessed output per
// cycle and reports the byte offsets of include paths named in line markers
// ("# N "path" 1" or "#line N "path""), plus a buffer-done result (ok, or
// corrupt when a path quote is still open) on each end_of_buffer byte. A byte
// is taken every cycle while the four-record queue between the scanner and
// the result sequencer has room; a byte that closes a span on the buffer's
// last byte needs two output transfers, and results leave one per cycle, so
// the input stalls only when results pile up faster than one per cycle or
// the output side holds off. Results pass the queue and sequencer registers.
// ----------------------------------------------------------------------------
// linemarker_include_scanner
// Top level: scanner front, record queue and result sequencer.
// ----------------------------------------------------------------------------
module linemarker_include_scanner
    import lis_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    t_rec front_rec;
    t_rec queue_rec;

    // Take a byte whenever the queue can hold its record
    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    lis_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    lis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_empty (empty),
        .o_full  (full)
    );

    lis_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (queue_rec),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/lis_port_checker.sv =====
// ----------------------------------------------------------------------------
// lis_port_checker
// Port-level checks of the line-marker include scanner, bound to its top.
// ----------------------------------------------------------------------------
`include "linemarker_include_scanner_assert.svh"

module lis_port_checker
    import lis_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic is_span;
    logic is_done;
    logic out_held;
    logic done_out;
    logic done_zero;

    assign is_span   = o_out_data.result_kind == KIND_SPAN;
    assign is_done   = (o_out_data.result_kind == KIND_OK) ||
                       (o_out_data.result_kind == KIND_CORRUPT);
    assign out_held  = o_out_valid && !i_out_ready;
    assign done_out  = o_out_valid && is_done;
    assign done_zero = (o_out_data.path_start == 32'd0) &&
                       (o_out_data.path_end == 32'd0);

    // Hold a stalled result
    `LIS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))

    // Only defined kinds leave the block
    `LIS_ASSERT_NOW(a_kind_known, i_clk, i_rst_n, o_out_valid, is_span || is_done)

    // A buffer-done result always closes its run
    `LIS_ASSERT_NOW(a_done_last, i_clk, i_rst_n, done_out, o_out_data.last_of_run)

    // A buffer-done result carries no offsets
    `LIS_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, done_out, done_zero)

endmodule

bind linemarker_include_scanner lis_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line-marker include scanner.
// A short directed table opens the run, followed by random buffers that are
// mostly well-formed line markers, with noise and broken markers mixed in.
// Each byte is scanned by a local predictor as it is accepted, and every
// result transfer is compared field by field with the oldest prediction.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import lis_pkg::*;

    localparam int POS_W        = 32;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    // Directed table columns: byte, end of buffer, typed expectation, kind
    localparam logic EOB   = 1'b1;
    localparam logic MID   = 1'b0;
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;
    localparam int DIRECTED_ROWS = 21;
    localparam logic [11:0] DIRECTED [0:DIRECTED_ROWS-1] = '{
        {8'hFF,     EOB, TYPED, KIND_OK},       // single-byte buffer
        {CH_HASH,   MID, PRED,  KIND_SPAN},     // "#  " then an open quote
        {CH_SPACE,  MID, PRED,  KIND_SPAN},
        {CH_SPACE,  MID, PRED,  KIND_SPAN},
        {CH_QUOTE,  EOB, TYPED, KIND_CORRUPT},  // buffer ends inside the path
        {CH_HASH,   MID, PRED,  KIND_SPAN},     // "#line 9 """: empty path
        {CH_L,      MID, PRED,  KIND_SPAN},
        {CH_I,      MID, PRED,  KIND_SPAN},
        {CH_N,      MID, PRED,  KIND_SPAN},
        {CH_E,      MID, PRED,  KIND_SPAN},
        {CH_SPACE,  MID, PRED,  KIND_SPAN},
        {CH_NINE,   MID, PRED,  KIND_SPAN},
        {CH_SPACE,  MID, PRED,  KIND_SPAN},
        {CH_QUOTE,  MID, PRED,  KIND_SPAN},
        {CH_QUOTE,  EOB, PRED,  KIND_SPAN},     // span and done on one byte
        {8'h01,     MID, PRED,  KIND_SPAN},     // byte 0x01, then zero byte
        {8'h00,     MID, PRED,  KIND_SPAN},
        {CH_HASH,   EOB, TYPED, KIND_OK},       // '#' not after a newline
        {CH_CR,     MID, PRED,  KIND_SPAN},     // CR opens, 'x' breaks it
        {CH_HASH,   MID, PRED,  KIND_SPAN},
        {8'h78,     EOB, TYPED, KIND_OK}
    };

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_row;

    logic clk;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_row cur_row  = '0;
    t_in  in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    assign in_data = cur_row.item;

    t_row text_q[$];
    t_out result_q[$];
    int   total_rows;
    int   sent_count = 0;
    int   fail_count = 0;
    int   idle_phase = 0;
    int   hold_left  = 0;
    bit   held_off   = 1'b0;
    int   stall_cycles = 0;

    // Scanner state mirrored by the predictor
    t_phase           scan_state;
    logic [7:0]       last_byte;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] span_begin;
    logic [POS_W-1:0] span_quote;
    logic             need_flag;

    linemarker_include_scanner #(
        .POS_WIDTH(POS_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Return the scanner to its state at buffer start
    task automatic clear_scan();
        scan_state = PH_SEARCH;
        last_byte  = CH_LF;
        offset     = '0;
        span_begin = '0;
        span_quote = '0;
        need_flag  = 1'b1;
    endtask

    // Scan one accepted byte and queue the results it causes
    task automatic scan_byte(t_row row);
        t_out       res [2];
        int         n;
        logic       retry;
        logic [7:0] b;
        n     = 0;
        retry = 1'b0;
        b     = row.item.text_byte;
        case (scan_state)
            PH_HASH: begin
                if (b == CH_SPACE) scan_state = PH_DIGITS;
                else if (b == CH_L) scan_state = PH_L_I;
                else retry = 1'b1;
            end
            PH_L_I: if (b == CH_I) scan_state = PH_L_N; else retry = 1'b1;
            PH_L_N: if (b == CH_N) scan_state = PH_L_E; else retry = 1'b1;
            PH_L_E: if (b == CH_E) scan_state = PH_L_SP; else retry = 1'b1;
            PH_L_SP: begin
                if (b == CH_SPACE) begin
                    need_flag  = 1'b0;
                    scan_state = PH_DIGITS;
                end else begin
                    retry = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (b >= CH_ZERO && b <= CH_NINE) scan_state = PH_DIGITS;
                else if (b == CH_SPACE) scan_state = PH_QUOTE;
                else retry = 1'b1;
            end
            PH_QUOTE: if (b == CH_QUOTE) scan_state = PH_PATH_FIRST; else retry = 1'b1;
            PH_PATH_FIRST, PH_PATH: begin
                if (scan_state == PH_PATH_FIRST && b == CH_LT) begin
                    retry = 1'b1;
                end else begin
                    if (scan_state == PH_PATH_FIRST) span_begin = offset;
                    if (b != CH_QUOTE) begin
                        scan_state = PH_PATH;
                    end else if (scan_state == PH_PATH &&
                                 (last_byte == CH_SLASH || last_byte == CH_BSLASH)) begin
                        // directory-like path: drop it
                        scan_state = PH_SEARCH;
                    end else if (!need_flag) begin
                        res[n] = '{KIND_SPAN, 32'(span_begin), 32'(offset), 1'b0};
                        n++;
                        scan_state = PH_SEARCH;
                    end else begin
                        span_quote = offset;
                        scan_state = PH_FLAG_SP;
                    end
                end
            end
            PH_FLAG_SP: if (b == CH_SPACE) scan_state = PH_FLAG_ONE; else retry = 1'b1;
            PH_FLAG_ONE: begin
                if (b == CH_ONE) begin
                    res[n] = '{KIND_SPAN, 32'(span_begin), 32'(span_quote), 1'b0};
                    n++;
                    scan_state = PH_SEARCH;
                end else begin
                    retry = 1'b1;
                end
            end
            default: retry = 1'b1;
        endcase

        // Rescan the breaking byte as a possible directive start
        if (retry) begin
            if (b == CH_HASH && (last_byte == CH_LF || last_byte == CH_CR))
                scan_state = PH_HASH;
            else
                scan_state = PH_SEARCH;
        end

        if (row.item.end_of_buffer) begin
            res[n] = '{(scan_state == PH_PATH || scan_state == PH_PATH_FIRST) ?
                       KIND_CORRUPT : KIND_OK, 32'd0, 32'd0, 1'b0};
            n++;
            clear_scan();
        end else begin
            last_byte = b;
            if (offset != {POS_W{1'b1}}) offset = offset + 1'b1;
        end

        if (n > 0) res[n-1].last_of_run = 1'b1;
        if (row.typed) begin
            result_q.push_back(row.want);
        end else begin
            for (int k = 0; k < n; k++) result_q.push_back(res[k]);
        end
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_result(t_out got);
        t_out want;
        if (result_q.size() == 0) begin
            $error("unexpected result: kind %0d start %0d end %0d",
                   got.result_kind, got.path_start, got.path_end);
            fail_count++;
        end else begin
            want = result_q.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, got %0d",
                       want.result_kind, got.result_kind);
                fail_count++;
            end
            if (got.path_start !== want.path_start) begin
                $error("path_start: expected %0d, got %0d", want.path_start, got.path_start);
                fail_count++;
            end
            if (got.path_end !== want.path_end) begin
                $error("path_end: expected %0d, got %0d", want.path_end, got.path_end);
                fail_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
                fail_count++;
            end
        end
    endtask

    // Idle percentage per phase: sender rare then heavy, receiver the reverse, none in the last
    function automatic int idle_pct(int phase, bit sender);
        case (phase)
            0:       return sender ? 7 : 68;
            1:       return sender ? 68 : 7;
            default: return 0;
        endcase
    endfunction

    // Append one random buffer: line markers, noise and broken markers
    task automatic append_buffer();
        logic [7:0] buf_q[$];
        logic [7:0] mark_q[$];
        logic [7:0] c;
        int         segs;
        int         kind;
        int         len;
        int         cut;
        bit         line_form;
        t_row       r;
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            mark_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 6 || kind == 7) begin
                // noise, biased toward bytes the scanner reacts to
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0:       mark_q.push_back(CH_HASH);
                        1:       mark_q.push_back(CH_LF);
                        2:       mark_q.push_back(CH_QUOTE);
                        default: mark_q.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end else begin
                // start on a fresh line unless at buffer start
                if (buf_q.size() != 0) begin
                    case ($urandom_range(0, 2))
                        0: mark_q.push_back(CH_LF);
                        1: mark_q.push_back(CH_CR);
                        default: begin
                            mark_q.push_back(CH_CR);
                            mark_q.push_back(CH_LF);
                        end
                    endcase
                end
                line_form = $urandom_range(0, 1);
                mark_q.push_back(CH_HASH);
                if (line_form) begin
                    mark_q.push_back(CH_L);
                    mark_q.push_back(CH_I);
                    mark_q.push_back(CH_N);
                    mark_q.push_back(CH_E);
                end
                mark_q.push_back(CH_SPACE);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++) mark_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                mark_q.push_back(CH_SPACE);
                mark_q.push_back(CH_QUOTE);
                case ($urandom_range(0, 9))
                    0: begin mark_q.push_back(CH_LT); len = $urandom_range(1, 4); end
                    1: len = 0;
                    default: len = $urandom_range(1, 6);
                endcase
                for (int k = 0; k < len; k++) begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    if (c == CH_QUOTE) c = 8'h61;
                    mark_q.push_back(c);
                end
                if ($urandom_range(0, 9) == 0)
                    mark_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
                mark_q.push_back(CH_QUOTE);
                // flag after the path in short form and sometimes in line form, " 1" half the time
                if (!line_form || $urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 5))
                        0: ;
                        1: begin mark_q.push_back(CH_SPACE); mark_q.push_back(8'h32); end
                        2: mark_q.push_back(CH_SPACE);
                        default: begin
                            mark_q.push_back(CH_SPACE);
                            mark_q.push_back(CH_ONE);
                            if ($urandom_range(0, 3) == 0) begin
                                mark_q.push_back(CH_SPACE);
                                mark_q.push_back(8'h33);
                            end
                        end
                    endcase
                end
                // broken marker: cut short or one byte corrupted
                if (kind == 8) begin
                    cut = $urandom_range(1, mark_q.size() - 1);
                    if ($urandom_range(0, 1)) begin
                        while (mark_q.size() > cut) void'(mark_q.pop_back());
                    end else begin
                        mark_q[cut] = 8'($urandom_range(1, 255));
                    end
                end
            end
            foreach (mark_q[k]) buf_q.push_back(mark_q[k]);
        end
        foreach (buf_q[k]) begin
            r = '0;
            r.item.text_byte     = buf_q[k];
            r.item.end_of_buffer = (k == buf_q.size() - 1);
            text_q.push_back(r);
        end
    endtask

    // Drive the input channel and predict each accepted byte
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                scan_byte(cur_row);
                sent_count++;
                if (sent_count >= 2 * total_rows / 3) idle_phase = 2;
                else if (sent_count >= total_rows / 3) idle_phase = 1;
            end
            if (!in_valid || in_ready) begin
                if (text_q.size() != 0 &&
                    $urandom_range(0, 99) >= idle_pct(idle_phase, 1'b1)) begin
                    cur_row  <= text_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check result transfers and pace the receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) check_result(out_data);
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (idle_phase == 2 && !held_off) begin
                // hold off long enough for the block to back up
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct(idle_phase, 1'b0));
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [11:0] w;
        t_row        r;
        clear_scan();
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            w = DIRECTED[k];
            r = '0;
            r.item.text_byte     = w[11:4];
            r.item.end_of_buffer = w[3];
            r.typed              = w[2];
            r.want               = '{w[1:0], 32'd0, 32'd0, 1'b1};
            text_q.push_back(r);
        end
        while (text_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) append_buffer();
        total_rows = text_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every byte, then every result, then a short drain
        while (sent_count < total_rows) @(posedge clk);
        while (result_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lis_pkg.sv
rtl/lis_front.sv
rtl/lis_queue.sv
rtl/lis_back.sv
rtl/linemarker_include_scanner.sv
rtl/lis_port_checker.sv
tb/sv/tb.sv
